### hw/rtl/swmf_pkg.sv
`default_nettype none

package swmf_pkg;

   localparam int WINDOW_MAX_DEF   = 64;
   localparam int SAMPLE_WIDTH_DEF = 32;

   // window_size register
   localparam int               WS_WIDTH = 7;
   localparam logic [WS_WIDTH-1:0] WS_RESET = WS_WIDTH'(1);

   // broadcast to every queue cell
   typedef struct packed {
      logic load;     // item accepted this cycle
      logic shift;    // queue moves one cell toward the front
      logic restart;  // treat all cells as empty
   } swmf_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/swmf_if.sv
`default_nettype none

interface swmf_req_if
   import swmf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swmf_rsp_if
   import swmf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] window_max;

   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

interface swmf_csr_if
   import swmf_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [WS_WIDTH-1:0] window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

### hw/rtl/swmf_cell.sv
`default_nettype none

// One slot of the candidate queue. Cells to the front hold larger or equal values.
module swmf_cell
   import swmf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire swmf_ctl_type                   ctl,
   input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
   input  wire logic signed [SAMPLE_WIDTH-1:0] rt_val,
   input  wire logic                           rt_occ,
   input  wire logic                           lf_keep,
   output logic                                keep,
   output logic signed [SAMPLE_WIDTH-1:0]      nxt_val,
   output logic signed [SAMPLE_WIDTH-1:0]      val,
   output logic                                occ
);

   logic signed [SAMPLE_WIDTH-1:0] val_ff;
   logic                           occ_ff;
   logic signed [SAMPLE_WIDTH-1:0] src_val;
   logic                           src_occ;

   always_comb begin
      src_val = ctl.shift ? rt_val : val_ff;
      src_occ = (ctl.shift ? rt_occ : occ_ff) && !ctl.restart;
      keep    = src_occ && (src_val >= sample);
      nxt_val = keep ? src_val : sample;
   end

   // occupancy is a prefix: this slot is filled next iff the one in front stays
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else if (ctl.load) begin
         occ_ff <= lf_keep;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         val_ff <= nxt_val;
      end
   end

   assign val = val_ff;
   assign occ = occ_ff;

endmodule

`default_nettype wire

### hw/rtl/swmf_history.sv
`default_nettype none

// Sample ring with registered read and same-cycle write forwarding.
module swmf_history
   import swmf_pkg::*;
#(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   localparam int PW          = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_en,
   input  wire logic [PW-1:0]                  wr_addr,
   input  wire logic signed [SAMPLE_WIDTH-1:0] wr_data,
   input  wire logic [PW-1:0]                  rd_addr,
   output logic signed [SAMPLE_WIDTH-1:0]      rd_data
);

   logic signed [SAMPLE_WIDTH-1:0] mem [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] rd_q_ff;
   logic signed [SAMPLE_WIDTH-1:0] byp_data_ff;
   logic                           byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff     <= mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;

endmodule

`default_nettype wire

### hw/rtl/sliding_window_max_filter.sv
`default_nettype none

// Channel  Dir  Payload                               Handshake
// req_ch   in   sample (signed), restart              valid/ready
// rsp_ch   out  window_max (signed)                   valid/ready
// csr_ch   in   window_size (7 bit)                   valid/ready, ready tied high
//
// One item per clock while the skid register is empty, set by a single pass
// through the cell row; a result is registered when its item is taken. The
// outgoing sample is read ahead from the ring, forwarded from the write when
// k is 1. Synchronous reset empties queue, fill count and ring pointer; window_size
// goes to 1; ring contents stay. Results pass an output register and one skid
// register; req_ch stalls only while the skid register holds an item.
module sliding_window_max_filter
   import swmf_pkg::*;
#(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   swmf_req_if.sink   req_ch,
   swmf_rsp_if.source rsp_ch,
   swmf_csr_if.sink   csr_ch
);

   localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CW = ((PW > WS_WIDTH) ? PW : WS_WIDTH) + 1;

   // effective window: 0 counts as 1, anything past the ring depth saturates
   function automatic logic [WS_WIDTH-1:0] clamp_k(input logic [WS_WIDTH-1:0] ws);
      logic [WS_WIDTH-1:0] k;
      k = ws;
      if (ws == '0) begin
         k = WS_WIDTH'(1);
      end else if (32'(ws) > 32'(WINDOW_MAX)) begin
         k = WS_WIDTH'(WINDOW_MAX);
      end
      return k;
   endfunction

   // ---- configuration ----
   logic [WS_WIDTH-1:0] ws_ff, ws_in;
   logic [WS_WIDTH-1:0] k, k_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      ws_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.window_size : ws_ff;
      k     = clamp_k(ws_ff);
      k_in  = clamp_k(ws_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= WS_RESET;
      end else begin
         ws_ff <= ws_in;
      end
   end

   // ---- input side ----
   logic                           accept;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           restart;
   logic                           skid_v_ff;

   assign req_ch.ready = !skid_v_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign sample       = req_ch.sample;
   assign restart      = req_ch.restart;

   // ---- fill count and ring pointer ----
   logic [WS_WIDTH-1:0] fill_ff, fill_in, fill_eff, fill_nxt;
   logic [PW-1:0]       ptr_ff, ptr_in;
   logic [PW-1:0]       rd_addr_in;
   logic [CW-1:0]       p_ext, k_ext;
   logic                win_full;    // outgoing sample is inside the ring
   logic                has_result;

   always_comb begin
      fill_eff   = restart ? '0 : fill_ff;
      win_full   = fill_eff >= k;
      fill_nxt   = (fill_eff < k) ? fill_eff + WS_WIDTH'(1) : fill_eff;
      has_result = fill_nxt >= k;
      fill_in    = accept ? fill_nxt : fill_ff;

      ptr_in = ptr_ff;
      if (accept) begin
         ptr_in = (32'(ptr_ff) == WINDOW_MAX - 1) ? '0 : ptr_ff + PW'(1);
      end

      // read address for the next item: k slots behind the pointer, wrapped
      p_ext      = CW'(ptr_in);
      k_ext      = CW'(k_in);
      rd_addr_in = (p_ext >= k_ext) ? PW'(p_ext - k_ext)
                                    : PW'(p_ext + CW'(WINDOW_MAX) - k_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         ptr_ff  <= ptr_in;
      end
   end

   logic signed [SAMPLE_WIDTH-1:0] old_sample;

   swmf_history #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_history (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (accept),
      .wr_addr(ptr_ff),
      .wr_data(sample),
      .rd_addr(rd_addr_in),
      .rd_data(old_sample)
   );

   // ---- candidate queue: row of cells, front at index 0 ----
   logic signed [SAMPLE_WIDTH-1:0] cell_val [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] cell_nxt [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]          cell_occ;
   logic [WINDOW_MAX-1:0]          cell_keep;
   logic                           drop_front;
   logic                           queue_full;
   swmf_ctl_type                   ctl;

   always_comb begin
      // the sample leaving the window retires the front if it is that value
      drop_front = win_full && cell_occ[0] && !restart && (cell_val[0] == old_sample);
      // every slot taken and nothing popped: oldest candidate falls out
      queue_full = cell_occ[WINDOW_MAX-1] && !restart && !drop_front
                   && (cell_val[WINDOW_MAX-1] >= sample);
      ctl.load    = accept;
      ctl.shift   = drop_front || queue_full;
      ctl.restart = restart;
   end

   for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] rt_val;
      logic                           rt_occ;
      logic                           lf_keep;

      if (j == WINDOW_MAX - 1) begin : g_last
         assign rt_val = '0;
         assign rt_occ = 1'b0;
      end else begin : g_mid
         assign rt_val = cell_val[j+1];
         assign rt_occ = cell_occ[j+1];
      end

      if (j == 0) begin : g_front
         assign lf_keep = 1'b1;
      end else begin : g_back
         assign lf_keep = cell_keep[j-1];
      end

      swmf_cell #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .sample (sample),
         .rt_val (rt_val),
         .rt_occ (rt_occ),
         .lf_keep(lf_keep),
         .keep   (cell_keep[j]),
         .nxt_val(cell_nxt[j]),
         .val    (cell_val[j]),
         .occ    (cell_occ[j])
      );
   end

   // ---- output register plus skid ----
   logic                           out_v_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_d_ff;
   logic signed [SAMPLE_WIDTH-1:0] skid_d_ff;
   logic                           new_item;
   logic                           out_free;

   assign new_item = accept && has_result;
   assign out_free = !out_v_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         // skid full means no item was taken this cycle
         out_v_ff  <= skid_v_ff || new_item;
         skid_v_ff <= 1'b0;
      end else if (new_item) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_d_ff <= skid_v_ff ? skid_d_ff : cell_nxt[0];
      end else if (new_item) begin
         skid_d_ff <= cell_nxt[0];
      end
   end

   assign rsp_ch.valid      = out_v_ff;
   assign rsp_ch.window_max = out_d_ff;

endmodule

`default_nettype wire

### hw/rtl/swmf_checker.sv
`default_nettype none

module swmf_checker
   import swmf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic signed [SAMPLE_WIDTH-1:0] window_max
);

   // a waiting result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(window_max))
      else $error("result changed or vanished while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // a result only appears after an item was taken
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an input item");

   // input stalls only behind a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

endmodule

bind sliding_window_max_filter swmf_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_swmf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .window_max(rsp_ch.window_max)
);

`default_nettype wire

### tb/window_max_checker.sv
`timescale 1ns / 100ps

// Watches the filter's channels, tracks its window state and checks each
// window_max against the oldest expected one.
module window_max_checker
   import swmf_pkg::*;
#(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                           req_restart,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] rsp_window_max,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [WS_WIDTH-1:0]            csr_window_size,
   output int                                  fail_count,
   output int                                  pending_maxima
);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   sample_type          candidates [WINDOW_MAX];
   int                  cand_count;
   sample_type          history [WINDOW_MAX];
   int                  hist_ptr;
   int                  fill_count;
   logic [WS_WIDTH-1:0] window_size;
   sample_type          expected_maxima [$];
   sample_type          oldest;

   function automatic int window_len();
      int k;
      k = int'(window_size);
      if (k == 0) k = 1;
      if (k > WINDOW_MAX) k = WINDOW_MAX;
      return k;
   endfunction

   function automatic void drop_front_candidate();
      if (cand_count == 0) return;
      for (int i = 0; i < cand_count - 1; i++) candidates[i] = candidates[i + 1];
      cand_count--;
   endfunction

   // one sample into the window; queues a maximum once the window is full
   function automatic void slide_window(sample_type s, logic restart);
      int k;
      int idx;
      k = window_len();
      if (restart) begin
         cand_count = 0;
         fill_count = 0;
      end
      if (fill_count >= k) begin
         idx = (hist_ptr + WINDOW_MAX - k) % WINDOW_MAX;
         if (cand_count > 0 && candidates[0] == history[idx]) drop_front_candidate();
      end
      while (cand_count > 0 && candidates[cand_count - 1] < s) cand_count--;
      if (cand_count >= WINDOW_MAX) drop_front_candidate();
      candidates[cand_count] = s;
      cand_count++;
      history[hist_ptr] = s;
      hist_ptr = (hist_ptr + 1) % WINDOW_MAX;
      if (fill_count < k) fill_count++;
      if (fill_count >= k) expected_maxima.push_back(candidates[0]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         window_size = WS_RESET;
         cand_count  = 0;
         hist_ptr    = 0;
         fill_count  = 0;
         fail_count  = 0;
         expected_maxima.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_maxima.size() == 0) begin
               $error("window_max: got %0d with nothing expected", rsp_window_max);
               fail_count++;
            end else begin
               oldest = expected_maxima[0];
               expected_maxima.delete(0);
               if (rsp_window_max !== oldest) begin
                  $error("window_max: expected %0d, actual %0d", oldest, rsp_window_max);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) window_size = csr_window_size;
         if (req_valid && req_ready) slide_window(req_sample, req_restart);
      end
      pending_maxima = expected_maxima.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import swmf_pkg::*;

   typedef logic signed [SAMPLE_WIDTH_DEF-1:0] sample_type;

   // how random samples are picked within a phase
   typedef enum {PAT_MIX, PAT_FALL} pattern_type;

   localparam sample_type S_MAX = {1'b0, {(SAMPLE_WIDTH_DEF-1){1'b1}}};
   localparam sample_type S_MIN = {1'b1, {(SAMPLE_WIDTH_DEF-1){1'b0}}};

   // cycles to let an item with no result finish before a register write
   localparam int SETTLE_CYCLES = 8;
   // one long receiver hold-off, long enough to back the block up
   localparam int LONG_HOLD     = 80;

   logic clock;
   logic reset;

   swmf_req_if req_ch ();
   swmf_rsp_if rsp_ch ();
   swmf_csr_if csr_ch ();

   int         mismatches;
   int         pending;
   int         send_idle;     // percent of cycles the sender sits out
   int         recv_idle;     // percent of cycles the receiver holds ready low
   bit         hold_request;  // asks the receiver process for one long hold-off
   sample_type last_sample;

   sliding_window_max_filter u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   window_max_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_sample      (req_ch.sample),
      .req_restart     (req_ch.restart),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_window_max  (rsp_ch.window_max),
      .csr_valid       (csr_ch.valid),
      .csr_ready       (csr_ch.ready),
      .csr_window_size (csr_ch.window_size),
      .fail_count      (mismatches),
      .pending_maxima  (pending)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #2_400_000;
      $display("simulation failed");
      $finish;
   end

   // receiver: random backpressure, plus one long hold-off on request,
   // counted here so the sender keeps offering items meanwhile
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   // Offer one item, with random idle cycles first. Returns at the falling
   // edge after acceptance with valid still high, so back-to-back items
   // never drop valid in between.
   task automatic send_item(input sample_type s, input logic r);
      while ($urandom_range(0, 99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.sample  <= s;
      req_ch.restart <= r;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // stop offering, wait for every expected maximum, then keep waiting
   // so that items with no result have left the block too
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_window(input logic [WS_WIDTH-1:0] k);
      csr_ch.valid       <= 1'b1;
      csr_ch.window_size <= k;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic sample_type next_sample(input pattern_type pat);
      sample_type s;
      if (pat == PAT_FALL) begin
         // strictly falling run: every sample stays a candidate
         s = last_sample - sample_type'($urandom_range(1, 1000));
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: s = sample_type'($urandom_range(0, 8)) - sample_type'(4);
            4, 5:       s = sample_type'($urandom);
            6: begin
               case ($urandom_range(0, 3))
                  0:       s = S_MAX;
                  1:       s = S_MIN;
                  2:       s = '0;
                  default: s = '1;
               endcase
            end
            7, 8:       s = last_sample + sample_type'($urandom_range(0, 6))
                            - sample_type'(3);
            default:    s = last_sample;   // repeat: equal candidates
         endcase
      end
      last_sample = s;
      return s;
   endfunction

   // One phase: drain, set the window, then a run of items.
   // fresh = first item restarts; without it the new window size lands
   // in the middle of a running sequence.
   // pause_at >= 0 makes the sender wait for all results at that item.
   task automatic run_phase(input int win, input int count, input bit fresh,
                            input pattern_type pat, input int s_idle, input int r_idle,
                            input bit long_hold, input int pause_at);
      int         eff;
      logic       r;
      sample_type s;
      settle();
      write_window(WS_WIDTH'(win));
      send_idle = s_idle;
      recv_idle = r_idle;
      eff = (win == 0) ? 1 : (win > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win;
      if (fresh && pat == PAT_FALL) last_sample = S_MAX;
      if (long_hold) hold_request = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) settle();
         r = (fresh && i == 0) ||
             (pat == PAT_MIX && $urandom_range(0, 3 * eff + 30) == 0);
         s = next_sample(pat);
         send_item(s, r);
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.sample      = '0;
      req_ch.restart     = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.window_size = '0;
      // sender idles 11%, receiver 61%
      send_idle          = 11;
      recv_idle          = 61;
      hold_request       = 1'b0;
      last_sample        = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: window size as it comes out of reset (1), field extremes
      send_item(S_MAX, 1'b1);
      send_item(S_MIN, 1'b0);
      send_item('0, 1'b0);
      send_item('1, 1'b0);
      send_item('1, 1'b0);

      // window of 3: equal values, extremes, restart before the window fills
      settle();
      write_window(WS_WIDTH'(3));
      send_item(sample_type'(5), 1'b1);
      send_item(sample_type'(5), 1'b0);
      send_item(sample_type'(5), 1'b0);
      send_item(S_MAX, 1'b0);
      send_item(S_MIN, 1'b0);
      send_item(S_MIN, 1'b0);
      send_item(S_MIN, 1'b0);
      send_item(sample_type'(7), 1'b0);
      send_item(sample_type'(2), 1'b1);
      send_item(sample_type'(3), 1'b0);
      send_item(sample_type'(3), 1'b0);
      send_item(sample_type'(2), 1'b0);
      send_item(sample_type'(1), 1'b0);

      // window size zero behaves as one
      settle();
      write_window('0);
      send_item(-sample_type'(3), 1'b0);
      send_item(sample_type'(4), 1'b0);
      send_item(S_MIN, 1'b1);

      // full window of falling samples fills the candidate queue ...
      run_phase(64, 80, 1'b1, PAT_FALL, 11, 61, 1'b0, -1);
      // ... then a shrink mid-sequence forces a push into a full queue
      run_phase(2, 20, 1'b0, PAT_FALL, 11, 61, 1'b0, -1);
      // all register bits set: saturates to the largest window
      run_phase(127, 70, 1'b1, PAT_MIX, 11, 61, 1'b0, -1);

      // sender idles 61%, receiver 11%; long hold-off backs the block up
      run_phase(5, 50, 1'b0, PAT_MIX, 61, 11, 1'b1, -1);
      run_phase(65, 70, 1'b1, PAT_MIX, 61, 11, 1'b0, -1);

      // no idling; sender waits for all results partway through one phase
      run_phase(16, 50, 1'b0, PAT_MIX, 0, 0, 1'b0, 25);
      run_phase(100, 30, 1'b0, PAT_MIX, 0, 0, 1'b0, -1);
      run_phase(8, 60, 1'b1, PAT_MIX, 0, 0, 1'b0, -1);
      run_phase(42, 30, 1'b1, PAT_MIX, 0, 0, 1'b0, -1);

      settle();
      if (mismatches == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/swmf_pkg.sv
hw/rtl/swmf_if.sv
hw/rtl/swmf_cell.sv
hw/rtl/swmf_history.sv
hw/rtl/sliding_window_max_filter.sv
hw/rtl/swmf_checker.sv
tb/window_max_checker.sv
tb/tb.sv
